// ===== hw/rtl/barrier_option_euler_path_unit_macros.svh =====
// Assertion macros for the barrier option Euler path unit.
// Clocked on clk and disabled while rst_n is low; both names must exist where used.
`ifndef BARRIER_OPTION_EULER_PATH_UNIT_MACROS_SVH
`define BARRIER_OPTION_EULER_PATH_UNIT_MACROS_SVH
`ifndef SYNTH
`define BOEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("boep assertion failed");
`define BOEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("boep assertion failed");
`else
`define BOEP_ASSERT_IMP(lbl, ante, cons)
`define BOEP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/boep_pkg.sv =====
// Shared constants for the barrier option Euler path unit.
// No dependencies; used by boep_mul and barrier_option_euler_path_unit.
package boep_pkg;

  localparam int DEF_MAX_STEPS  = 4096;
  localparam int DEF_PRICE_BITS = 32;

  // Register port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPOT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BARRIER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KIND    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANTI    = 3'd7;

  localparam logic KIND_UO_CALL = 1'b0;
  localparam logic KIND_DI_PUT  = 1'b1;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 31;
  localparam int STEPS_W  = 13;
  localparam int OUT_W    = 32;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 13'd252;

  // Arithmetic
  localparam int SAMPLE_FRAC = 12;
  localparam int FRAC_W      = 30;
  localparam int VZ_W        = VOL_W + SAMPLE_W;
  localparam int S_W         = 48;
  localparam int DIG_W       = 16;
  localparam int NDIG        = 3;
  localparam int DIG_CNT_W   = 2;
  localparam int MAG_W       = DIG_W * NDIG;

endpackage

// ===== hw/rtl/boep_mul.sv =====
// Shared multiplier of the Euler path unit: unsigned operand times one 16-bit digit.
// Result is registered. Depends on boep_pkg.
module boep_mul #(
  parameter int A_W = 32
) (
  input  logic                            clk,
  input  logic                            mul_en,
  input  logic [A_W-1:0]                  mul_a,
  input  logic [boep_pkg::DIG_W-1:0]      mul_b,
  output logic [A_W+boep_pkg::DIG_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

endmodule

// ===== hw/rtl/barrier_option_euler_path_unit.sv =====
// Top level of the barrier option Euler path unit: register file, sequencer and datapath.
// Depends on boep_pkg, boep_mul and barrier_option_euler_path_unit_macros.svh.
//
// Usage: one standard normal draw is transferred on the in_ channel per time step.
// Each draw moves a primary and a mirror price by one Euler step, using a single
// shared multiplier: one product for volatility times draw, then three 16-bit
// digit products per path for price times rate, under a small sequencer.
// A draw occupies the unit after its transfer, and in_ready returns for a new draw
// only once both paths have been through the multiplier loop and updated.
// After the last draw of a path the states ST_PAY and ST_EMIT form the payoffs and
// place the result in the out_ register.
// The out_ register holds the result until the receiver takes it. Draws keep
// being accepted meanwhile; only a path end that finds the register still full
// waits until the earlier result has been transferred.
// Configuration writes through cfg_ take effect at once and should only be made
// while the unit is idle. spot_r is used from the next path start.
// Reset (synchronous, rst_n low) restores the configuration and sequencer registers
// to their defaults, empties the output register and starts a fresh path.
`include "barrier_option_euler_path_unit_macros.svh"
module barrier_option_euler_path_unit #(
  parameter int MAX_STEPS  = boep_pkg::DEF_MAX_STEPS,
  parameter int PRICE_BITS = boep_pkg::DEF_PRICE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [boep_pkg::SAMPLE_W-1:0] in_normal_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [boep_pkg::OUT_W-1:0]          out_payoff,
  output logic [boep_pkg::OUT_W-1:0]          out_vanilla_payoff,
  output logic                                out_barrier_event,
  output logic [boep_pkg::OUT_W-1:0]          out_final_price,
  input  logic                                cfg_we,
  input  logic [boep_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [boep_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int PW      = PRICE_BITS;
  localparam int W       = (PW > boep_pkg::OUT_W) ? PW : boep_pkg::OUT_W;
  localparam int MUL_A_W = (PW > boep_pkg::VOL_W) ? PW : boep_pkg::VOL_W;
  localparam int PROD_W  = MUL_A_W + boep_pkg::DIG_W;
  localparam int ACC_W   = PW + boep_pkg::MAG_W;
  localparam int DELTA_W = ACC_W - boep_pkg::FRAC_W;
  localparam int SUM_W   = DELTA_W + 1;
  localparam int SIDX_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW      = ($clog2(MAX_STEPS + 1) > boep_pkg::STEPS_W) ?
                           $clog2(MAX_STEPS + 1) : boep_pkg::STEPS_W;
  localparam int S_W     = boep_pkg::S_W;
  localparam int DIG_W   = boep_pkg::DIG_W;
  localparam int MAG_W   = boep_pkg::MAG_W;
  localparam int OUT_W   = boep_pkg::OUT_W;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_VZ   = 10'b0000000010,
    ST_VZW  = 10'b0000000100,
    ST_SUM  = 10'b0000001000,
    ST_MAG  = 10'b0000010000,
    ST_MUL  = 10'b0000100000,
    ST_UPD  = 10'b0001000000,
    ST_TCH  = 10'b0010000000,
    ST_PAY  = 10'b0100000000,
    ST_EMIT = 10'b1000000000
  } state_t;

  // Configuration registers
  logic [31:0]                         spot_r;
  logic [31:0]                         strike_r;
  logic [31:0]                         barrier_r;
  logic [31:0]                         drift_r;
  logic [boep_pkg::VOL_W-1:0]          vol_r;
  logic [boep_pkg::STEPS_W-1:0]        steps_r;
  logic                                kind_r;
  logic                                anti_r;

  // Sequencer and path state
  state_t                              state_r, state_nxt;
  logic [SIDX_W-1:0]                   step_idx_r;
  logic                                cur_mirror_r;
  logic [boep_pkg::DIG_CNT_W-1:0]      dig_r;
  logic [PW-1:0]                       price_r;
  logic [PW-1:0]                       mirror_r;
  logic                                path_t_r;
  logic                                mirror_t_r;

  // Datapath registers
  logic [boep_pkg::SAMPLE_W-1:0]       z_r;
  logic [boep_pkg::VZ_W-1:0]           vz_r;
  logic [S_W-1:0]                      s_r;
  logic [MAG_W-1:0]                    mag_r;
  logic                                neg_r;
  logic [ACC_W-1:0]                    acc_r;
  logic [W-1:0]                        pay1_r;
  logic [W-1:0]                        pay2_r;
  logic [W-1:0]                        van_r;

  // Output register
  logic                                out_valid_r;
  logic [OUT_W-1:0]                    out_payoff_r;
  logic [OUT_W-1:0]                    out_van_r;
  logic                                out_event_r;
  logic [OUT_W-1:0]                    out_final_r;

  // Combinational
  logic                                in_fire;
  logic                                out_free;
  logic                                mul_en;
  logic [MUL_A_W-1:0]                  mul_a;
  logic [DIG_W-1:0]                    mul_b;
  logic [PROD_W-1:0]                   prod_r;
  logic [boep_pkg::SAMPLE_W-1:0]       zmag;
  logic [PW-1:0]                       cur_price;
  logic [PW-1:0]                       spot_p;
  logic                                spot_touch;
  logic                                cur_touch;
  logic [S_W-1:0]                      drift_ext;
  logic [S_W-1:0]                      vz_ext;
  logic [S_W-1:0]                      s_nxt;
  logic [S_W-1:0]                      abs_rnd;
  logic [MAG_W-1:0]                    mag_nxt;
  logic [ACC_W-1:0]                    acc_nxt;
  logic [DELTA_W-1:0]                  delta;
  logic [SUM_W-1:0]                    up_sum;
  logic [PW-1:0]                       new_price;
  logic [CW-1:0]                       cnt_eff;
  logic                                last_step;
  logic [W-1:0]                        fin_w;
  logic [W-1:0]                        mfin_w;
  logic [W-1:0]                        strike_w;
  logic [W-1:0]                        pay1_nxt;
  logic [W-1:0]                        pay2_nxt;
  logic [W-1:0]                        van_nxt;
  logic [W:0]                          pair_sum;
  logic [W-1:0]                        pay_sel;

  function automatic logic touches(input logic [W-1:0] p, input logic [W-1:0] bar,
                                   input logic kind);
    if (kind == boep_pkg::KIND_DI_PUT) begin
      return p <= bar;
    end
    return p >= bar;
  endfunction

  function automatic logic [W-1:0] payoff_of(input logic [W-1:0] fin,
                                             input logic [W-1:0] strk,
                                             input logic touched, input logic kind);
    logic [W-1:0] res;
    res = '0;
    if (kind == boep_pkg::KIND_UO_CALL) begin
      if (!touched && fin > strk) begin
        res = fin - strk;
      end
    end else begin
      if (touched && strk > fin) begin
        res = strk - fin;
      end
    end
    return res;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [W-1:0] v);
    logic [OUT_W-1:0] res;
    res = v[OUT_W-1:0];
    if ((v >> OUT_W) != '0) begin
      res = '1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r    <= '0;
      strike_r  <= '0;
      barrier_r <= '1;
      drift_r   <= '0;
      vol_r     <= '0;
      steps_r   <= boep_pkg::STEPS_RESET;
      kind_r    <= boep_pkg::KIND_UO_CALL;
      anti_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        boep_pkg::REG_SPOT:    spot_r    <= cfg_wdata;
        boep_pkg::REG_STRIKE:  strike_r  <= cfg_wdata;
        boep_pkg::REG_BARRIER: barrier_r <= cfg_wdata;
        boep_pkg::REG_DRIFT:   drift_r   <= cfg_wdata;
        boep_pkg::REG_VOL:     vol_r     <= cfg_wdata[boep_pkg::VOL_W-1:0];
        boep_pkg::REG_STEPS:   steps_r   <= cfg_wdata[boep_pkg::STEPS_W-1:0];
        boep_pkg::REG_KIND:    kind_r    <= cfg_wdata[0];
        boep_pkg::REG_ANTI:    anti_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------------
  assign zmag = z_r[boep_pkg::SAMPLE_W-1] ? (~z_r + 16'd1) : z_r;
  assign cur_price = cur_mirror_r ? mirror_r : price_r;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = MUL_A_W'(cur_price);
    mul_b  = mag_r[MAG_W-1 -: DIG_W];
    if (state_r == ST_VZ) begin
      mul_en = 1'b1;
      mul_a  = MUL_A_W'(vol_r);
      mul_b  = zmag;
    end else if (state_r == ST_MUL && dig_r != boep_pkg::DIG_CNT_W'(boep_pkg::NDIG)) begin
      mul_en = 1'b1;
    end
  end

  boep_mul #(
    .A_W (MUL_A_W)
  ) u_mul (
    .clk    (clk),
    .mul_en (mul_en),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // ---------------------------------------------------------------------------
  // Datapath logic
  // ---------------------------------------------------------------------------
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign spot_p     = PW'(spot_r);
  assign spot_touch = touches(W'(spot_p), W'(barrier_r), kind_r);
  assign cur_touch  = touches(W'(cur_price), W'(barrier_r), kind_r);

  // The mirror path uses the negated draw, so its sign of vol times draw flips.
  assign drift_ext = {{(S_W - 32 - boep_pkg::SAMPLE_FRAC){drift_r[31]}}, drift_r,
                      {boep_pkg::SAMPLE_FRAC{1'b0}}};
  assign vz_ext    = S_W'(vz_r);
  assign s_nxt     = (z_r[boep_pkg::SAMPLE_W-1] ^ cur_mirror_r) ? (drift_ext - vz_ext) :
                                                                   (drift_ext + vz_ext);

  // Magnitude rounded half up to Q.30: for negative s, ~s + 1 + half.
  assign abs_rnd = s_r[S_W-1] ?
                   (~s_r + S_W'((1 << (boep_pkg::SAMPLE_FRAC - 1)) + 1)) :
                   (s_r + S_W'(1 << (boep_pkg::SAMPLE_FRAC - 1)));
  assign mag_nxt = MAG_W'(abs_rnd >> boep_pkg::SAMPLE_FRAC);

  // Digits arrive most significant first; the rounding half joins the last add.
  always_comb begin
    acc_nxt = (acc_r << DIG_W) + ACC_W'(prod_r[PW+DIG_W-1:0]);
    if (dig_r == boep_pkg::DIG_CNT_W'(boep_pkg::NDIG)) begin
      acc_nxt = acc_nxt + (ACC_W'(1) << (boep_pkg::FRAC_W - 1));
    end
  end

  assign delta  = acc_r[ACC_W-1:boep_pkg::FRAC_W];
  assign up_sum = SUM_W'(delta) + SUM_W'(cur_price);

  always_comb begin
    if (neg_r) begin
      if (delta >= DELTA_W'(cur_price)) begin
        new_price = '0;
      end else begin
        new_price = cur_price - delta[PW-1:0];
      end
    end else begin
      if (up_sum[SUM_W-1:PW] != '0) begin
        new_price = '1;
      end else begin
        new_price = up_sum[PW-1:0];
      end
    end
  end

  always_comb begin
    priority if (steps_r == '0) begin
      cnt_eff = CW'(1);
    end else if (CW'(steps_r) > CW'(MAX_STEPS)) begin
      cnt_eff = CW'(MAX_STEPS);
    end else begin
      cnt_eff = CW'(steps_r);
    end
  end
  assign last_step = (CW'(step_idx_r) + CW'(1)) >= cnt_eff;

  assign fin_w    = W'(price_r);
  assign mfin_w   = W'(mirror_r);
  assign strike_w = W'(strike_r);
  assign pay1_nxt = payoff_of(fin_w, strike_w, path_t_r, kind_r);
  assign pay2_nxt = payoff_of(mfin_w, strike_w, mirror_t_r, kind_r);
  assign van_nxt  = (fin_w > strike_w) ? (fin_w - strike_w) : '0;
  assign pair_sum = {1'b0, pay1_r} + {1'b0, pay2_r};
  assign pay_sel  = anti_r ? pair_sum[W:1] : pay1_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_VZ;
      ST_VZ:   state_nxt = ST_VZW;
      ST_VZW:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (dig_r == boep_pkg::DIG_CNT_W'(boep_pkg::NDIG)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:  state_nxt = ST_TCH;
      ST_TCH: begin
        priority if (!cur_mirror_r) begin
          state_nxt = ST_SUM;
        end else if (last_step) begin
          state_nxt = ST_PAY;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAY:  state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_idx_r   <= '0;
      cur_mirror_r <= 1'b0;
      dig_r        <= '0;
      path_t_r     <= 1'b0;
      mirror_t_r   <= 1'b0;
      price_r      <= '0;
      mirror_r     <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cur_mirror_r <= 1'b0;
            // A new path reloads both prices and checks the start price.
            if (step_idx_r == '0) begin
              price_r    <= spot_p;
              mirror_r   <= spot_p;
              path_t_r   <= spot_touch;
              mirror_t_r <= spot_touch;
            end
          end
        end
        ST_MAG: dig_r <= '0;
        ST_MUL: dig_r <= dig_r + boep_pkg::DIG_CNT_W'(1);
        ST_UPD: begin
          if (cur_mirror_r) begin
            mirror_r <= new_price;
          end else begin
            price_r <= new_price;
          end
        end
        ST_TCH: begin
          if (cur_mirror_r) begin
            mirror_t_r <= mirror_t_r | cur_touch;
            if (!last_step) begin
              step_idx_r <= step_idx_r + SIDX_W'(1);
            end
          end else begin
            path_t_r     <= path_t_r | cur_touch;
            cur_mirror_r <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            step_idx_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      z_r <= in_normal_sample;
    end
    if (state_r == ST_VZW) begin
      vz_r <= prod_r[boep_pkg::VZ_W-1:0];
    end
    if (state_r == ST_SUM) begin
      s_r <= s_nxt;
    end
    if (state_r == ST_MAG) begin
      mag_r <= mag_nxt;
      neg_r <= s_r[S_W-1];
      acc_r <= '0;
    end
    if (state_r == ST_MUL) begin
      if (dig_r != '0) begin
        acc_r <= acc_nxt;
      end
      mag_r <= mag_r << DIG_W;
    end
    if (state_r == ST_PAY) begin
      pay1_r <= pay1_nxt;
      pay2_r <= pay2_nxt;
      van_r  <= van_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_payoff_r <= sat_out(pay_sel);
      out_van_r    <= sat_out(van_r);
      out_event_r  <= path_t_r;
      out_final_r  <= sat_out(fin_w);
    end
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_payoff         = out_payoff_r;
  assign out_vanilla_payoff = out_van_r;
  assign out_barrier_event  = out_event_r;
  assign out_final_price    = out_final_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BOEP_ASSERT_NXT(a_pending_result_kept, state_r == ST_EMIT && out_valid_r && !out_ready, state_r == ST_EMIT && $stable(out_payoff_r))
  `BOEP_ASSERT_NXT(a_emit_loads_output, state_r == ST_EMIT && out_free, out_valid_r && state_r == ST_IDLE)
  `BOEP_ASSERT_NXT(a_busy_after_transfer, in_fire, !in_ready && state_r == ST_VZ)
  `BOEP_ASSERT_IMP(a_digit_count_bound, state_r == ST_MUL, dig_r <= boep_pkg::DIG_CNT_W'(boep_pkg::NDIG))

endmodule

// ===== sim/barrier_option_euler_path_unit_test.sv =====
// Self-checking testbench for barrier_option_euler_path_unit: drives normal draws and register
// settings, predicts every path result in-house and compares it with the out_ channel.
// Depends on boep_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module barrier_option_euler_path_unit_test;

  typedef struct {
    logic [31:0]                  spot;
    logic [31:0]                  strike;
    logic [31:0]                  barrier;
    logic signed [31:0]           drift;
    logic [boep_pkg::VOL_W-1:0]   vol;
    logic [boep_pkg::STEPS_W-1:0] steps;
    logic                         kind;
    logic                         anti;
  } setup_t;

  typedef struct {
    logic [boep_pkg::OUT_W-1:0] payoff;
    logic [boep_pkg::OUT_W-1:0] vanilla;
    logic                       touched;
    logic [boep_pkg::OUT_W-1:0] final_px;
  } path_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [boep_pkg::SAMPLE_W-1:0] in_normal_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [boep_pkg::OUT_W-1:0] out_payoff, out_vanilla_payoff, out_final_price;
  logic out_barrier_event;
  logic cfg_we = 1'b0;
  logic [boep_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [boep_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Register copies and path state as the unit should hold them.
  setup_t cfg_now = '{spot: 32'd0, strike: 32'd0, barrier: 32'hFFFF_FFFF, drift: 32'sd0,
                      vol: '0, steps: boep_pkg::STEPS_RESET, kind: boep_pkg::KIND_UO_CALL,
                      anti: 1'b0};
  logic [31:0] path_px = '0, mirror_px = '0;
  logic path_hit = 1'b0, mirror_hit = 1'b0;
  int steps_done = 0;
  path_result_t due_results[$];

  int mismatches = 0;
  int paths_checked = 0;
  int draws_sent = 0;
  int directed_draws = 0;
  int setups_applied = 0;
  int gap_left = 0;
  int sink_hold_cycles = 0;
  bit pacing_on = 1'b1;

  barrier_option_euler_path_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_normal_sample(in_normal_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_payoff(out_payoff), .out_vanilla_payoff(out_vanilla_payoff),
    .out_barrier_event(out_barrier_event), .out_final_price(out_final_price),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int path_length(input logic [boep_pkg::STEPS_W-1:0] steps);
    if (steps == 0) return 1;
    if (steps > boep_pkg::DEF_MAX_STEPS) return boep_pkg::DEF_MAX_STEPS;
    return int'(steps);
  endfunction

  function automatic logic hits_barrier(input logic [31:0] px);
    if (cfg_now.kind == boep_pkg::KIND_DI_PUT) return px <= cfg_now.barrier;
    return px >= cfg_now.barrier;
  endfunction

  // One Euler move: the rate drift + vol * draw is rounded from Q.42 to Q.30 on its magnitude,
  // then the price change is rounded half up and the price clamped at zero or the format top.
  function automatic logic [31:0] euler_step_price(input logic [31:0] px, input int z);
    longint rate;
    logic [63:0] rate_mag, m30, delta;
    logic [127:0] prod;
    rate = longint'(cfg_now.drift) * 64'sd4096 + longint'(cfg_now.vol) * longint'(z);
    rate_mag = (rate < 0) ? 64'(-rate) : 64'(rate);
    m30 = (rate_mag + 64'd2048) >> 12;
    prod = 128'(px) * 128'(m30) + (128'd1 << 29);
    delta = 64'(prod >> 30);
    if (rate < 0) return (delta >= 64'(px)) ? 32'd0 : px - 32'(delta);
    return (delta > 64'(32'hFFFF_FFFF - px)) ? 32'hFFFF_FFFF : px + 32'(delta);
  endfunction

  function automatic logic [32:0] barrier_value(input logic [31:0] fin, input logic hit);
    if (cfg_now.kind == boep_pkg::KIND_UO_CALL)
      return (!hit && fin > cfg_now.strike) ? {1'b0, fin - cfg_now.strike} : 33'd0;
    return (hit && cfg_now.strike > fin) ? {1'b0, cfg_now.strike - fin} : 33'd0;
  endfunction

  function automatic void path_step(input logic signed [boep_pkg::SAMPLE_W-1:0] sample);
    int zi;
    logic [32:0] pay;
    path_result_t r;
    zi = int'(sample);
    if (steps_done == 0) begin
      path_px = cfg_now.spot;
      mirror_px = cfg_now.spot;
      path_hit = hits_barrier(cfg_now.spot);
      mirror_hit = path_hit;
    end
    path_px = euler_step_price(path_px, zi);
    mirror_px = euler_step_price(mirror_px, -zi);
    if (hits_barrier(path_px)) path_hit = 1'b1;
    if (hits_barrier(mirror_px)) mirror_hit = 1'b1;
    steps_done++;
    // A step count lowered below the draws already taken ends the path here as well.
    if (steps_done >= path_length(cfg_now.steps)) begin
      pay = barrier_value(path_px, path_hit);
      if (cfg_now.anti) pay = (pay + barrier_value(mirror_px, mirror_hit)) >> 1;
      r.payoff = pay[31:0];
      r.vanilla = (path_px > cfg_now.strike) ? path_px - cfg_now.strike : 32'd0;
      r.touched = path_hit;
      r.final_px = path_px;
      due_results.push_back(r);
      steps_done = 0;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int pick_gap();
    int r;
    if (!pacing_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [boep_pkg::SAMPLE_W-1:0] normal_draw();
    int acc;
    if ($urandom_range(0, 19) == 0) return 16'($urandom);
    acc = $urandom_range(0, 8191) + $urandom_range(0, 8191) + $urandom_range(0, 8191)
          + $urandom_range(0, 8191) - 16382;
    return 16'(acc);
  endfunction

  function automatic setup_t market_setup();
    setup_t m;
    int unsigned s0;
    int r;
    s0 = ($urandom_range(50, 200) << 16) | $urandom_range(0, 65535);
    m.spot = s0;
    m.strike = $urandom_range(s0 - s0 / 5, s0 + s0 / 5);
    m.kind = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 10) m.barrier = $urandom_range(s0 - s0 / 50, s0 + s0 / 50);
    else if (m.kind == boep_pkg::KIND_UO_CALL)
      m.barrier = $urandom_range(s0 + s0 / 20, s0 + s0 / 2);
    else m.barrier = $urandom_range(s0 / 2, s0 - s0 / 20);
    m.drift = int'($urandom_range(0, 1 << 20)) - 524288;
    m.vol = 31'($urandom_range(1 << 22, 1 << 26));
    r = $urandom_range(0, 99);
    if (r < 60) m.steps = 13'($urandom_range(1, 8));
    else if (r < 90) m.steps = 13'($urandom_range(9, 40));
    else if (r < 98) m.steps = 13'($urandom_range(41, 120));
    else m.steps = boep_pkg::STEPS_RESET;
    m.anti = 1'($urandom_range(0, 1));
    return m;
  endfunction

  function automatic setup_t noise_setup();
    setup_t m;
    m.spot = $urandom;
    m.strike = $urandom;
    m.barrier = $urandom;
    m.drift = $urandom;
    m.vol = 31'($urandom);
    m.steps = 13'($urandom_range(0, 12));
    m.kind = 1'($urandom_range(0, 1));
    m.anti = 1'($urandom_range(0, 1));
    return m;
  endfunction

  task automatic write_reg(input logic [boep_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    unique case (idx)
      boep_pkg::REG_SPOT:    cfg_now.spot = val;
      boep_pkg::REG_STRIKE:  cfg_now.strike = val;
      boep_pkg::REG_BARRIER: cfg_now.barrier = val;
      boep_pkg::REG_DRIFT:   cfg_now.drift = val;
      boep_pkg::REG_VOL:     cfg_now.vol = val[boep_pkg::VOL_W-1:0];
      boep_pkg::REG_STEPS:   cfg_now.steps = val[boep_pkg::STEPS_W-1:0];
      boep_pkg::REG_KIND:    cfg_now.kind = val[0];
      boep_pkg::REG_ANTI:    cfg_now.anti = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input setup_t m);
    write_reg(boep_pkg::REG_SPOT, m.spot);
    write_reg(boep_pkg::REG_STRIKE, m.strike);
    write_reg(boep_pkg::REG_BARRIER, m.barrier);
    write_reg(boep_pkg::REG_DRIFT, m.drift);
    write_reg(boep_pkg::REG_VOL, 32'(m.vol));
    write_reg(boep_pkg::REG_STEPS, 32'(m.steps));
    write_reg(boep_pkg::REG_KIND, 32'(m.kind));
    write_reg(boep_pkg::REG_ANTI, 32'(m.anti));
    cfg_we <= 1'b0;
    setups_applied++;
  endtask

  // Valid is only dropped when a gap follows, so back-to-back transfers keep it high.
  task automatic send_draw(input logic signed [boep_pkg::SAMPLE_W-1:0] z);
    repeat (gap_left) @(posedge clk);
    in_valid <= 1'b1;
    in_normal_sample <= z;
    do @(posedge clk); while (!in_ready);
    path_step(z);
    draws_sent++;
    gap_left = pick_gap();
    if (gap_left != 0) in_valid <= 1'b0;
  endtask

  // Must be called in the same time step as the last transfer.
  task automatic settle();
    if (gap_left == 0) in_valid <= 1'b0;
    gap_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    // A draw that ends no path may still be in the multiplier loop.
    repeat (30) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) $display("[%0t] path result error: %s", $time, what);
  endtask

  always @(posedge clk) begin
    path_result_t want;
    if (rst_n && out_valid && out_ready) begin
      paths_checked++;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, final price %h", out_final_price));
      end else begin
        want = due_results.pop_front();
        if (out_payoff !== want.payoff)
          flag_mismatch($sformatf("payoff %h, predicted %h", out_payoff, want.payoff));
        if (out_vanilla_payoff !== want.vanilla)
          flag_mismatch($sformatf("vanilla payoff %h, predicted %h",
                                  out_vanilla_payoff, want.vanilla));
        if (out_barrier_event !== want.touched)
          flag_mismatch($sformatf("barrier event %b, predicted %b",
                                  out_barrier_event, want.touched));
        if (out_final_price !== want.final_px)
          flag_mismatch($sformatf("final price %h, predicted %h",
                                  out_final_price, want.final_px));
      end
    end
  end

  // Receiver pacing; a long hold-off requested by a test is counted out here.
  initial begin : sink_pacing
    int hold;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        hold = sink_hold_cycles;
        sink_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
        out_ready <= 1'b1;
      end else if (pacing_on && $urandom_range(0, 5) == 0) begin
        hold = 1 + pick_gap();
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Only the step count is written, so every other register keeps its reset value.
  task automatic test_reset_defaults();
    write_reg(boep_pkg::REG_STEPS, 32'd2);
    cfg_we <= 1'b0;
    send_draw(16'sh1234);
    send_draw(-16'sd777);
    settle();
  endtask

  task automatic test_extreme_draws();
    setup_t m;
    m = '{spot: 32'h0064_0000, strike: 32'h0064_0000, barrier: 32'h0078_0000,
          drift: 32'sd429497, vol: 31'h0CCC_CCCD, steps: 13'd1,
          kind: boep_pkg::KIND_UO_CALL, anti: 1'b1};
    apply_setup(m);
    send_draw(16'sh7FFF);
    send_draw(16'sh8000);
    send_draw(16'sh0000);
    send_draw(16'sh0001);
    send_draw(16'shFFFF);
    settle();
    m.kind = boep_pkg::KIND_DI_PUT;
    m.barrier = 32'h0050_0000;
    m.anti = 1'b0;
    apply_setup(m);
    send_draw(16'sh8000);
    send_draw(16'sh7FFF);
    send_draw(16'sh0000);
    settle();
  endtask

  // Prices driven into the top of the format and down to zero.
  task automatic test_saturation_and_clamp();
    setup_t m;
    m = '{spot: 32'hF000_0000, strike: 32'd0, barrier: 32'hFFFF_FFFF, drift: 32'sh7FFF_FFFF,
          vol: 31'h7FFF_FFFF, steps: 13'd1, kind: boep_pkg::KIND_UO_CALL, anti: 1'b1};
    apply_setup(m);
    send_draw(16'sh7FFF);
    send_draw(16'sh8000);
    settle();
    write_reg(boep_pkg::REG_DRIFT, 32'h8000_0000);
    cfg_we <= 1'b0;
    send_draw(16'sh0000);
    settle();
  endtask

  // The spot itself already sits on the barrier.
  task automatic test_touch_at_start();
    setup_t m;
    m = '{spot: 32'h0064_0000, strike: 32'h0032_0000, barrier: 32'h0064_0000, drift: 32'sd0,
          vol: '0, steps: 13'd1, kind: boep_pkg::KIND_UO_CALL, anti: 1'b1};
    apply_setup(m);
    send_draw(normal_draw());
    settle();
    m.kind = boep_pkg::KIND_DI_PUT;
    m.strike = 32'h0096_0000;
    apply_setup(m);
    send_draw(normal_draw());
    settle();
  endtask

  task automatic test_step_count_rules();
    setup_t m;
    m = market_setup();
    m.steps = 13'd0;
    apply_setup(m);
    send_draw(normal_draw());
    send_draw(normal_draw());
    settle();
    // Leave a path half done, then shorten it; the new spot waits for the next path.
    write_reg(boep_pkg::REG_STEPS, 32'd6);
    cfg_we <= 1'b0;
    repeat (3) send_draw(normal_draw());
    settle();
    write_reg(boep_pkg::REG_STEPS, 32'd2);
    write_reg(boep_pkg::REG_SPOT, 32'h0080_0000);
    cfg_we <= 1'b0;
    repeat (3) send_draw(normal_draw());
    settle();
  endtask

  // The receiver holds off while every draw ends a path, so the unit has to stall its input.
  task automatic test_output_backpressure();
    setup_t m;
    m = market_setup();
    m.steps = 13'd1;
    pacing_on = 1'b0;
    apply_setup(m);
    sink_hold_cycles = 400;
    repeat (24) send_draw(normal_draw());
    settle();
    pacing_on = 1'b1;
  endtask

  task automatic test_random_paths(input int budget);
    setup_t m;
    int span, n;
    while (draws_sent < budget) begin
      m = ($urandom_range(0, 99) < 85) ? market_setup() : noise_setup();
      pacing_on = ($urandom_range(0, 4) != 0);
      apply_setup(m);
      span = path_length(m.steps);
      n = (span > 60) ? span : span * $urandom_range(1, 5);
      // Now and then stop mid-path so the next setting lands on a running path.
      if ($urandom_range(0, 3) == 0) n += $urandom_range(0, span - 1);
      repeat (n) send_draw(normal_draw());
      settle();
    end
    pacing_on = 1'b1;
  endtask

  // A step count above the maximum whose low bits are small must not end the path early;
  // the path is then closed by lowering the count.
  task automatic test_capped_path();
    setup_t m;
    m = market_setup();
    m.steps = 13'h1003;
    m.vol = 31'($urandom_range(1 << 20, 1 << 22));
    pacing_on = 1'b0;
    apply_setup(m);
    repeat (10) send_draw(normal_draw());
    settle();
    write_reg(boep_pkg::REG_STEPS, 32'd1);
    cfg_we <= 1'b0;
    send_draw(normal_draw());
    settle();
    pacing_on = 1'b1;
  endtask

  initial begin : run_tests
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_draws();
    test_saturation_and_clamp();
    test_touch_at_start();
    test_step_count_rules();
    directed_draws = draws_sent;
    test_output_backpressure();
    test_random_paths(1700);
    test_capped_path();
    repeat (40) @(posedge clk);
    $display("Covered %0d draws (%0d directed, one path with an oversized step count) over %0d settings.",
             draws_sent, directed_draws, setups_applied);
    $display("%0d path results compared, %0d errors.", paths_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
